### rtl/msrnr_pkg.sv
// Shared types, sizes and codes for the MIDI switch router with note release.
package msrnr_pkg;

    // Bitmap geometry.
    localparam int CHANNELS          = 16;
    localparam int NOTES_PER_CHANNEL = 128;
    localparam int WORD_BITS         = 64;
    localparam int WORDS_PER_CHANNEL = NOTES_PER_CHANNEL / WORD_BITS;
    localparam int MAP_WORDS         = CHANNELS * WORDS_PER_CHANNEL;
    localparam int IDX_W             = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W             = $clog2(WORD_BITS);
    localparam int CH_W              = 4;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Input opcodes.
    localparam logic OP_MIDI   = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // Result kinds.
    localparam logic RES_FWD   = 1'b0;
    localparam logic RES_BATCH = 1'b1;

    // MIDI status high nibbles of interest.
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [MAP_WORDS-1:0] t_nz;
    typedef logic [WORD_BITS-1:0] t_word;

    // One input transaction.
    typedef struct packed {
        logic       opcode;
        logic [1:0] source_port;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] msg_length;
        logic       target_sel;
    } t_in;

    // One output transaction.
    typedef struct packed {
        logic        kind;
        logic        out_port;
        logic [7:0]  out_status;
        logic [6:0]  out_data_one;
        logic [6:0]  out_data_two;
        logic [1:0]  out_length;
        logic [3:0]  off_channel;
        logic        off_half;
        logic [63:0] off_mask;
        logic        last;
    } t_res;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic             is_target;
        logic             tsel;
        logic             is_note;
        logic             note_on;
        t_idx             idx;
        logic [BIT_W-1:0] bit_pos;
        logic [1:0]       port;
        logic [7:0]       status;
        logic [6:0]       d1;
        logic [6:0]       d2;
        logic [1:0]       len;
    } t_cmd;

endpackage

### rtl/midi_switch_router_note_release.sv
// Top level of the MIDI switch router with note release on a routing change.
//
//   Channel   Direction  Signals                               Payload
//   input     in         i_in_valid, o_in_ready, i_in_data     msrnr_pkg::t_in
//   result    out        o_out_valid, i_out_ready, o_out_data  msrnr_pkg::t_res
//
// A note message passes through the back part as dequeue, map read, map write
// and, when routed, result register; any other message as dequeue and result
// register when routed. A target change that alters the target walks every map
// word, in a scan state for an empty word and a scan then a wait state for a
// word with active notes.
// Reset clears the active-word flags, so no clearing pass is run.
// The front accepts transactions while the back part is busy, until the
// four-entry queue fills; a stalled result holds only the back part.
module midi_switch_router_note_release (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  msrnr_pkg::t_in  i_in_data,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output msrnr_pkg::t_res o_out_data,
    input  logic            i_out_ready
);
    import msrnr_pkg::*;

    logic front_valid;
    t_cmd front_cmd;
    logic q_full;
    logic q_empty;
    t_cmd q_cmd;
    logic q_pop;

    // Classification stage.
    msrnr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (!q_full)
    );

    // Command queue.
    msrnr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // Execution.
    msrnr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );
endmodule

### rtl/msrnr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module msrnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/msrnr_front.sv
// Front part: accepts input transactions and classifies them into commands.
module msrnr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  msrnr_pkg::t_in  i_in_data,
    output logic            o_in_ready,
    output logic            o_cmd_valid,
    output msrnr_pkg::t_cmd o_cmd,
    input  logic            i_cmd_ready
);
    import msrnr_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic [3:0] ch;
    logic [3:0] kind;
    logic       ch_ok;

    // Decode the status byte and work out where a note event lands in the bitmap.
    always_comb begin
        ch    = i_in_data.status_byte[3:0];
        kind  = i_in_data.status_byte[7:4];
        ch_ok = ({1'b0, ch} < 5'(CHANNELS));

        n_cmd           = '0;
        n_cmd.is_target = (i_in_data.opcode == OP_TARGET);
        n_cmd.tsel      = i_in_data.target_sel;
        n_cmd.is_note   = (i_in_data.opcode == OP_MIDI) && ch_ok &&
                          ((kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF));
        n_cmd.note_on   = (kind == KIND_NOTE_ON);
        n_cmd.idx       = IDX_W'({ch, i_in_data.data_one[6]});
        n_cmd.bit_pos   = i_in_data.data_one[BIT_W-1:0];
        n_cmd.port      = i_in_data.source_port;
        n_cmd.status    = i_in_data.status_byte;
        n_cmd.d1        = i_in_data.data_one;
        n_cmd.d2        = i_in_data.data_two;
        n_cmd.len       = i_in_data.msg_length;
    end

    // One holding stage in front of the queue.
    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

### rtl/msrnr_fifo.sv
// Short command queue between the front and back parts.
module msrnr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msrnr_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output msrnr_pkg::t_cmd o_data,
    output logic            o_empty
);
    import msrnr_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wptr;
    logic [Q_AW:0] r_rptr;

    // Pointers carry one wrap bit to tell full from empty.
    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[Q_AW] != r_rptr[Q_AW]) &&
                     (r_wptr[Q_AW-1:0] == r_rptr[Q_AW-1:0]);
    assign o_data  = r_mem[r_rptr[Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr[Q_AW-1:0]] <= i_data;
        end
    end
endmodule

### rtl/msrnr_back.sv
// Back part: bitmap updates, forwarding and note-off release scans.
module msrnr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  msrnr_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    output logic            o_out_valid,
    output msrnr_pkg::t_res o_out_data,
    input  logic            i_out_ready
);
    import msrnr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RD    = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_FWD   = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_SWAIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_idx   r_idx;
    t_idx   n_idx;
    t_cmd   r_cmd;
    logic   r_target;
    t_nz    r_nz;
    logic   r_ovalid;
    t_res   r_out;

    logic   out_free;
    logic   we;
    logic   load_out;
    logic   finish;
    t_res   res;
    t_word  rd_data;
    t_word  old_word;
    t_word  bit_vec;
    t_word  new_word;
    t_nz    lower_nz;
    logic   routed;
    t_res   fwd_res;
    t_res   batch_res;

    // Note bitmap; a word whose nonzero bit is clear reads as zero.
    msrnr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (new_word),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Read-modify-write value for a note event.
    always_comb begin
        old_word = r_nz[r_idx] ? rd_data : '0;
        bit_vec  = t_word'(1) << r_cmd.bit_pos;
        new_word = r_cmd.note_on ? (old_word | bit_vec) : (old_word & ~bit_vec);
    end

    // Candidate results.
    always_comb begin
        routed   = (r_cmd.port[1] == r_target);
        lower_nz = r_nz & ~(t_nz'('1) << r_idx);

        fwd_res              = '0;
        fwd_res.kind         = RES_FWD;
        fwd_res.out_port     = r_cmd.port[0];
        fwd_res.out_status   = r_cmd.status;
        fwd_res.out_data_one = r_cmd.d1;
        fwd_res.out_data_two = r_cmd.d2;
        fwd_res.out_length   = r_cmd.len;
        fwd_res.last         = 1'b1;

        batch_res             = '0;
        batch_res.kind        = RES_BATCH;
        batch_res.off_channel = CH_W'(r_idx >> 1);
        batch_res.off_half    = r_idx[0];
        batch_res.off_mask    = rd_data;
        batch_res.last        = (lower_nz == '0);
    end

    assign out_free = !r_ovalid || i_out_ready;

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_cmd_pop = 1'b0;
        we        = 1'b0;
        load_out  = 1'b0;
        finish    = 1'b0;
        res       = fwd_res;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_target) begin
                        if (i_cmd.tsel != r_target) begin
                            n_idx   = IDX_W'(MAP_WORDS - 1);
                            n_state = ST_SCAN;
                        end
                    end else if (i_cmd.is_note) begin
                        n_idx   = i_cmd.idx;
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_FWD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                we      = 1'b1;
                n_state = routed ? ST_FWD : ST_IDLE;
            end
            ST_FWD: begin
                if (!routed) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_nz[r_idx]) begin
                    n_state = ST_SWAIT;
                end else if (r_idx == '0) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ST_SWAIT: begin
                res = batch_res;
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_idx == '0) begin
                        finish  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_target <= 1'b0;
            r_nz     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_target <= r_cmd.tsel;
                r_nz     <= '0;
            end else if (we) begin
                r_nz[r_idx] <= (new_word != '0);
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

### rtl/msrnr_chk.sv
// Port-level assertions for the MIDI switch router, bound to the top level.
module msrnr_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input msrnr_pkg::t_in  i_in_data,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input msrnr_pkg::t_res o_out_data,
    input logic            i_out_ready
);
    import msrnr_pkg::*;

    // A stalled result stays on offer unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A forwarded message is always the only result of its transaction.
    a_fwd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == RES_FWD) |->
            o_out_data.last && (o_out_data.off_mask == '0))
        else $error("forwarded message malformed");

    // Only words with active notes produce a note-off batch.
    a_batch_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == RES_BATCH) |->
            (o_out_data.off_mask != '0) && (o_out_data.out_status == '0))
        else $error("empty or malformed note-off batch");

    // A batch that is not last is followed by a batch for a lower map word.
    a_batch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out_data.kind == RES_BATCH) &&
            !o_out_data.last |=>
            !o_out_valid || ((o_out_data.kind == RES_BATCH) &&
            ({o_out_data.off_channel, o_out_data.off_half} <
             $past({o_out_data.off_channel, o_out_data.off_half}))))
        else $error("note-off batches out of order");
endmodule

bind midi_switch_router_note_release msrnr_chk u_chk (.*);
